// File: hw/rtl/rtc_pkg.sv
// Package: shared types, register codes and constants of the closest-hit block.
`default_nettype none
package rtc_pkg;

    // Configuration register codes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    // Arithmetic widths: triple products fit in 100 signed bits
    localparam int ACC_W       = 100;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_CNT_W   = 6;

    localparam logic [ACC_W-1:0]     DET_MIN_MAG = 100'd281475;
    localparam logic [31:0]          NO_HIT      = 32'hFFFF_FFFF;
    localparam logic [31:0]          GAMMA_SAT   = 32'hFFFF_FFFE;
    localparam logic [DIV_CNT_W-1:0] GAMMA_BITS  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] LAMBDA_BITS = 6'd31;

    // One triangle request
    typedef struct packed {
        logic               first_of_ray;
        logic signed [31:0] vert_a_x;
        logic signed [31:0] vert_a_y;
        logic signed [31:0] vert_a_z;
        logic signed [31:0] edge_ab_x;
        logic signed [31:0] edge_ab_y;
        logic signed [31:0] edge_ab_z;
        logic signed [31:0] edge_ac_x;
        logic signed [31:0] edge_ac_y;
        logic signed [31:0] edge_ac_z;
    } t_tri_in;

    // One result
    typedef struct packed {
        logic        hit_now;
        logic        hit_any;
        logic [31:0] closest_distance;
        logic [30:0] best_lambda2;
        logic [30:0] best_lambda3;
        logic [15:0] best_index;
    } t_res;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } t_vec3;

    // Prepared triangle: h = origin - A, c = -dir, edges widened
    typedef struct packed {
        logic  first;
        t_vec3 ab;
        t_vec3 ac;
        t_vec3 h;
        t_vec3 c;
    } t_work;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic             lambda;
        logic [ACC_W-1:0] num;
        logic [ACC_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
    } t_div_rsp;

    // Component pick: 0 = x, 1 = y, 2 = z
    function automatic logic signed [32:0] sel3(t_vec3 v, logic [1:0] k);
        logic signed [32:0] r;
        case (k)
            2'd0:    r = v.x;
            2'd1:    r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rtc_fifo.sv
// Small register queue with show-ahead read.
`default_nettype none
module rtc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rtc_front.sv
// Front end: ray registers, triangle intake, h and c preparation, work queue.
`default_nettype none
module rtc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire rtc_pkg::t_tri_in                i_tri,
    input  wire logic                            i_cfg_we,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [31:0]                     i_cfg_data,
    output rtc_pkg::t_work                       o_work,
    output logic                                 o_empty,
    input  wire logic                            i_pop
);
    import rtc_pkg::*;

    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic signed [31:0] r_dir_x, r_dir_y, r_dir_z;
    t_work              w_work;
    logic [$bits(t_work)-1:0] w_head;

    // ray registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_DIR_X:    r_dir_x <= i_cfg_data;
                CFG_DIR_Y:    r_dir_y <= i_cfg_data;
                CFG_DIR_Z:    r_dir_z <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // widen to 33 bits, form h and c
    always_comb begin
        w_work.first = i_tri.first_of_ray;
        w_work.ab.x  = {i_tri.edge_ab_x[31], i_tri.edge_ab_x};
        w_work.ab.y  = {i_tri.edge_ab_y[31], i_tri.edge_ab_y};
        w_work.ab.z  = {i_tri.edge_ab_z[31], i_tri.edge_ab_z};
        w_work.ac.x  = {i_tri.edge_ac_x[31], i_tri.edge_ac_x};
        w_work.ac.y  = {i_tri.edge_ac_y[31], i_tri.edge_ac_y};
        w_work.ac.z  = {i_tri.edge_ac_z[31], i_tri.edge_ac_z};
        w_work.h.x   = $signed({r_org_x[31], r_org_x}) - $signed({i_tri.vert_a_x[31],
                                                                 i_tri.vert_a_x});
        w_work.h.y   = $signed({r_org_y[31], r_org_y}) - $signed({i_tri.vert_a_y[31],
                                                                 i_tri.vert_a_y});
        w_work.h.z   = $signed({r_org_z[31], r_org_z}) - $signed({i_tri.vert_a_z[31],
                                                                 i_tri.vert_a_z});
        w_work.c.x   = -$signed({r_dir_x[31], r_dir_x});
        w_work.c.y   = -$signed({r_dir_y[31], r_dir_y});
        w_work.c.z   = -$signed({r_dir_z[31], r_dir_z});
    end

    rtc_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_work),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (w_head),
        .o_empty (o_empty)
    );

    assign o_work = t_work'(w_head);
endmodule
`default_nettype wire

// File: hw/rtl/rtc_div.sv
// Restoring divider, one quotient bit per cycle, for gamma and the lambdas.
`default_nettype none
module rtc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rtc_pkg::t_div_req i_req,
    output rtc_pkg::t_div_rsp      o_rsp
);
    import rtc_pkg::*;

    logic [ACC_W-1:0]     r_rem, r_den;
    logic [31:0]          r_bits, r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [ACC_W-1:0]     w_trial;
    logic [ACC_W:0]       w_diff;
    logic                 w_ge;

    // shift in next dividend bit and try the subtract
    assign w_trial = {r_rem[ACC_W-2:0], r_bits[31]};
    assign w_diff  = {1'b0, w_trial} - {1'b0, r_den};
    assign w_ge    = !w_diff[ACC_W];

    // datapath; gamma divides num*2^16, a lambda num*2^30
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            r_q   <= '0;
            if (i_req.lambda) begin
                r_rem  <= i_req.num >> 1;
                r_bits <= {i_req.num[0], 31'b0};
            end else begin
                r_rem  <= i_req.num >> 16;
                r_bits <= {i_req.num[15:0], 16'b0};
            end
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[ACC_W-1:0] : w_trial;
            r_bits <= {r_bits[30:0], 1'b0};
            r_q    <= {r_q[30:0], w_ge};
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.lambda ? LAMBDA_BITS : GAMMA_BITS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/rtc_back.sv
// Back end: triple-product sequencer on a shared multiplier, tests, closest-hit state.
`default_nettype none
module rtc_back #(
    parameter int MAX_TRIANGLES = 65536
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rtc_pkg::t_work i_work,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_push,
    output rtc_pkg::t_res       o_res,
    input  wire logic           i_full
);
    import rtc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TRIANGLES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_NORM  = 4'd2;
    localparam logic [3:0] S_TEST1 = 4'd3;
    localparam logic [3:0] S_TEST2 = 4'd4;
    localparam logic [3:0] S_DIVG  = 4'd5;
    localparam logic [3:0] S_GCHK  = 4'd6;
    localparam logic [3:0] S_DIVL2 = 4'd7;
    localparam logic [3:0] S_DIVL3 = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // passes: D and Ng share AB x AC; then N2, then N3
    localparam logic [1:0] PASS_DG = 2'd0;
    localparam logic [1:0] PASS_N2 = 2'd1;
    localparam logic [1:0] PASS_N3 = 2'd2;

    logic [3:0]              r_state;
    t_work                   r_w;
    logic [1:0]              r_pass, r_k;
    logic [2:0]              r_step;
    logic signed [65:0]      r_p, r_t0;
    logic signed [64:0]      r_comp;
    logic signed [ACC_W-1:0] r_acc_d, r_acc_g, r_acc_2, r_acc_3;
    logic                    r_hit;
    logic [31:0]             r_gq;
    logic [30:0]             r_l2;
    logic [15:0]             r_idx;

    logic [31:0]             r_closest;
    logic [30:0]             r_kl2, r_kl3;
    logic [15:0]             r_kidx;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_any;

    logic [1:0]              w_ki, w_kj;
    t_vec3                   w_u, w_v;
    logic signed [32:0]      w_ma, w_mb, w_lo, w_hi;
    logic signed [65:0]      w_diff;
    logic [ACC_W-1:0]        w_pext, w_pshift;
    logic [2:0]              w_last;
    logic [CNT_W-1:0]        w_base;
    logic [ACC_W:0]          w_sum23;
    logic                    w_gsat;
    t_div_req                w_dreq;
    t_div_rsp                w_drsp;

    // component order of the cross product
    always_comb begin
        case (r_k)
            2'd0:    begin w_ki = 2'd1; w_kj = 2'd2; end
            2'd1:    begin w_ki = 2'd2; w_kj = 2'd0; end
            default: begin w_ki = 2'd0; w_kj = 2'd1; end
        endcase
    end

    // operand vectors of the current pass
    always_comb begin
        case (r_pass)
            PASS_DG: begin w_u = r_w.ab; w_v = r_w.ac; end
            PASS_N2: begin w_u = r_w.h;  w_v = r_w.ac; end
            default: begin w_u = r_w.ab; w_v = r_w.h;  end
        endcase
    end

    assign w_lo   = $signed({1'b0, r_comp[31:0]});
    assign w_hi   = $signed(r_comp[64:32]);
    assign w_last = (r_pass == PASS_DG) ? 3'd7 : 3'd5;

    // multiplier operand select per micro step
    always_comb begin
        case (r_step)
            3'd0:    begin w_ma = sel3(w_u, w_ki); w_mb = sel3(w_v, w_kj); end
            3'd1:    begin w_ma = sel3(w_u, w_kj); w_mb = sel3(w_v, w_ki); end
            3'd3:    begin w_ma = w_lo; w_mb = sel3(r_w.c, r_k); end
            3'd4:    begin w_ma = w_hi; w_mb = sel3(r_w.c, r_k); end
            3'd5:    begin w_ma = w_lo; w_mb = sel3(r_w.h, r_k); end
            3'd6:    begin w_ma = w_hi; w_mb = sel3(r_w.h, r_k); end
            default: begin w_ma = '0;   w_mb = '0; end
        endcase
    end

    assign w_diff   = r_t0 - r_p;
    assign w_pext   = {{(ACC_W-66){r_p[65]}}, r_p};
    assign w_pshift = {{(ACC_W-98){r_p[65]}}, r_p, 32'b0};
    assign w_base   = i_work.first ? '0 : r_cnt;
    assign w_sum23  = {1'b0, r_acc_2} + {1'b0, r_acc_3};
    assign w_gsat   = ({16'b0, r_acc_g} >= {r_acc_d, 16'b0});

    // divider requests
    always_comb begin
        w_dreq.den    = r_acc_d;
        w_dreq.start  = 1'b0;
        w_dreq.lambda = 1'b1;
        w_dreq.num    = r_acc_2;
        case (r_state)
            S_TEST2: begin
                w_dreq.lambda = 1'b0;
                w_dreq.num    = r_acc_g;
                w_dreq.start  = !(r_acc_3[ACC_W-1] || (r_acc_3 > r_acc_d)
                                 || (w_sum23 > {1'b0, r_acc_d}) || w_gsat);
            end
            S_GCHK: begin
                w_dreq.start = !((r_gq == '0) || (r_gq > r_closest));
            end
            S_DIVL2: begin
                w_dreq.num   = r_acc_3;
                w_dreq.start = w_drsp.done;
            end
            default: ;
        endcase
    end

    rtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // shared 33x33 multiplier, registered
    always_ff @(posedge i_clk) begin
        r_p <= w_ma * w_mb;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_w     <= i_work;
                r_acc_d <= '0;
                r_acc_g <= '0;
                r_acc_2 <= '0;
                r_acc_3 <= '0;
                r_hit   <= 1'b0;
                r_idx   <= 16'(w_base);
            end
            S_MUL: begin
                case (r_step)
                    3'd1: r_t0   <= r_p;
                    3'd2: r_comp <= w_diff[64:0];
                    3'd4, 3'd5: begin
                        case (r_pass)
                            PASS_DG: r_acc_d <= r_acc_d +
                                                ((r_step == 3'd4) ? w_pext : w_pshift);
                            PASS_N2: r_acc_2 <= r_acc_2 +
                                                ((r_step == 3'd4) ? w_pext : w_pshift);
                            default: r_acc_3 <= r_acc_3 +
                                                ((r_step == 3'd4) ? w_pext : w_pshift);
                        endcase
                    end
                    3'd6: r_acc_g <= r_acc_g + w_pext;
                    3'd7: r_acc_g <= r_acc_g + w_pshift;
                    default: ;
                endcase
            end
            S_NORM: begin
                // make the determinant nonnegative
                if (r_acc_d[ACC_W-1]) begin
                    r_acc_d <= -r_acc_d;
                    r_acc_g <= -r_acc_g;
                    r_acc_2 <= -r_acc_2;
                    r_acc_3 <= -r_acc_3;
                end
            end
            S_TEST2: begin
                if (w_gsat) begin
                    r_gq <= GAMMA_SAT;
                end
            end
            S_DIVG: begin
                if (w_drsp.done) begin
                    r_gq <= (w_drsp.q == NO_HIT) ? GAMMA_SAT : w_drsp.q;
                end
            end
            S_DIVL2: begin
                if (w_drsp.done) begin
                    r_l2 <= w_drsp.q[30:0];
                end
            end
            S_DIVL3: begin
                if (w_drsp.done) begin
                    r_hit <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // sequencer and closest-hit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pass    <= PASS_DG;
            r_k       <= '0;
            r_step    <= '0;
            r_closest <= NO_HIT;
            r_kl2     <= '0;
            r_kl3     <= '0;
            r_kidx    <= '0;
            r_cnt     <= '0;
            r_any     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        if (i_work.first) begin
                            r_closest <= NO_HIT;
                            r_kl2     <= '0;
                            r_kl3     <= '0;
                            r_kidx    <= '0;
                            r_any     <= 1'b0;
                        end
                        r_cnt   <= (w_base == CNT_W'(MAX_TRIANGLES - 1)) ? '0
                                                                       : w_base + 1'b1;
                        r_pass  <= PASS_DG;
                        r_k     <= '0;
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == w_last) begin
                        r_step <= '0;
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            if (r_pass == PASS_N3) begin
                                r_state <= S_NORM;
                            end else begin
                                r_pass <= r_pass + 1'b1;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_NORM: r_state <= S_TEST1;
                S_TEST1: begin
                    // parallel ray, behind origin, lambda2 out of range
                    if ((r_acc_d < DET_MIN_MAG) || r_acc_g[ACC_W-1] || (r_acc_g == '0)
                        || r_acc_2[ACC_W-1] || (r_acc_2 > r_acc_d)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TEST2;
                    end
                end
                S_TEST2: begin
                    if (r_acc_3[ACC_W-1] || (r_acc_3 > r_acc_d)
                        || (w_sum23 > {1'b0, r_acc_d})) begin
                        r_state <= S_DONE;
                    end else if (w_gsat) begin
                        r_state <= S_GCHK;
                    end else begin
                        r_state <= S_DIVG;
                    end
                end
                S_DIVG: begin
                    if (w_drsp.done) begin
                        r_state <= S_GCHK;
                    end
                end
                S_GCHK: begin
                    r_state <= w_dreq.start ? S_DIVL2 : S_DONE;
                end
                S_DIVL2: begin
                    if (w_drsp.done) begin
                        r_state <= S_DIVL3;
                    end
                end
                S_DIVL3: begin
                    if (w_drsp.done) begin
                        r_closest <= r_gq;
                        r_kl2     <= r_l2;
                        r_kl3     <= w_drsp.q[30:0];
                        r_kidx    <= r_idx;
                        r_any     <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_push = (r_state == S_DONE) && !i_full;

    always_comb begin
        o_res.hit_now          = r_hit;
        o_res.hit_any          = r_any;
        o_res.closest_distance = r_closest;
        o_res.best_lambda2     = r_kl2;
        o_res.best_lambda3     = r_kl3;
        o_res.best_index       = r_kidx;
    end
endmodule
`default_nettype wire

// File: hw/rtl/ray_triangle_closest_hit.sv
// Closest ray-triangle hit search: front end, work queue, back end, result queue.
//
// Usage: write the ray origin and direction through the config port (index 0..5,
// origin x/y/z then direction x/y/z, signed Q16.16) while the block is idle.
// Triangles enter as queue pushes (push/full); set first_of_ray on the first
// triangle of each ray to clear the kept hit and the triangle count.
// Every triangle produces exactly one result, read as a queue (empty/pop),
// holding the closest hit so far for the current ray.
// Back-end time per triangle depends on the test that ends it: the determinant,
// distance sign or lambda2 test, the lambda3 or sum test, the gamma division when
// it shows the triangle farther than the kept hit, or, for a hit, both lambda
// divisions (gamma division skipped if gamma saturates), done one at a time.
// That time is set by the 42 products of the triple products on one shared
// 33x33 multiplier and by the divider, which yields one quotient bit per cycle.
// A two-entry work queue lets triangles be taken while the back end is busy;
// a two-entry result queue holds results while the reader stalls, and the back
// end waits with a finished result once that queue is full.
// Reset (synchronous, active low) clears the ray registers, the kept hit,
// the triangle counter and both queues.
`default_nettype none
module ray_triangle_closest_hit #(
    parameter int MAX_TRIANGLES = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire rtc_pkg::t_tri_in              i_tri,
    output logic                               empty,
    input  wire logic                          pop,
    output rtc_pkg::t_res                      o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data
);
    import rtc_pkg::*;

    t_work                   w_work;
    logic                    w_work_empty, w_work_pop;
    logic                    w_res_push, w_res_full;
    t_res                    w_res;
    logic [$bits(t_res)-1:0] w_res_head;

    rtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_tri      (i_tri),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_work     (w_work),
        .o_empty    (w_work_empty),
        .i_pop      (w_work_pop)
    );

    rtc_back #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_work),
        .i_empty (w_work_empty),
        .o_pop   (w_work_pop),
        .o_push  (w_res_push),
        .o_res   (w_res),
        .i_full  (w_res_full)
    );

    rtc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_head),
        .o_empty (empty)
    );

    assign o_res = t_res'(w_res_head);

    // back end only offers a result when the result queue has room
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_any_matches_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.hit_any == (o_res.closest_distance != NO_HIT)))
        else $error("hit_any disagrees with distance code");

    a_now_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.hit_now) |-> o_res.hit_any)
        else $error("hit_now without hit_any");
endmodule
`default_nettype wire
